// ----- sv/overflow_extended_interval_timer_defines.svh -----
// Assertion helpers shared by the timer project.
// Both sample on aclk and are switched off while aresetn is low.
`ifndef OVERFLOW_EXTENDED_INTERVAL_TIMER_DEFINES_SVH
`define OVERFLOW_EXTENDED_INTERVAL_TIMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OEIT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OEIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/oeit_pkg.sv -----
`timescale 1ns / 1ps

package oeit_pkg;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_STOP  = 2'd2;

    // Timer modes; any mode beyond execute-once behaves as periodic reload.
    localparam logic [1:0] MODE_FREE = 2'd0;
    localparam logic [1:0] MODE_ONCE = 2'd1;

    // Prescaler selects.
    localparam logic [2:0] PSC_OFF      = 3'd0;
    localparam logic [2:0] PSC_SEL_1    = 3'd1;
    localparam logic [2:0] PSC_SEL_8    = 3'd2;
    localparam logic [2:0] PSC_SEL_64   = 3'd3;
    localparam logic [2:0] PSC_SEL_256  = 3'd4;
    localparam logic [2:0] PSC_SEL_1024 = 3'd5;

    localparam int DIVC_W = 11;

    // Interval arithmetic widths: ms * 1e6 fits 36 bits, the tick period 21 bits.
    localparam int          DVD_W     = 36;
    localparam int          DVS_W     = 21;
    localparam int          DIV_CNT_W = 6;
    localparam logic [19:0] MS_TO_NS  = 20'd1000000;
    localparam logic [15:0] OVF_MAX   = 16'hFFFF;

    // Command queue between the front and the back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  prescale_sel;
        logic [15:0] desired_ms;
    } in_item_t;

    typedef struct packed {
        logic [23:0] tick_count;
        logic        running;
        logic        complete;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_TICK,
        CMD_START,
        CMD_STOP
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [2:0]  sel;
        logic [15:0] ms;
    } q_item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_FIN
    } bk_state_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [DIVC_W-1:0] psc_divisor(input logic [2:0] sel);
        logic [DIVC_W-1:0] d;
        case (sel)
            PSC_SEL_1:    d = 11'd1;
            PSC_SEL_8:    d = 11'd8;
            PSC_SEL_64:   d = 11'd64;
            PSC_SEL_256:  d = 11'd256;
            PSC_SEL_1024: d = 11'd1024;
            default:      d = 11'd0;
        endcase
        return d;
    endfunction

endpackage

// ----- sv/overflow_extended_interval_timer.sv -----
// Ticks, stops, no-ops and free-running starts are executed as they are taken from the queue,
// their results registered; the next is taken once the output register is free or being read.
// A start in a countdown mode holds the back while it is taken, the 36-bit serial divider
// is started, the quotient bits are produced, the quotient is seen and the timer is loaded.
// Reset (aresetn low, synchronous) stops the timer, clears all counters, empties the
// queue and the output register, and selects free-running mode.
`timescale 1ns / 1ps

`include "overflow_extended_interval_timer_defines.svh"

module overflow_extended_interval_timer import oeit_pkg::*; #(
    parameter int COUNTER_BITS = 8,
    parameter int CLOCK_HZ     = 16000000
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    // The user must write the mode register only while the block is idle (the block does not
    // enforce it), so a countdown start sees the same mode from the moment it is taken until it completes.
    logic [1:0] timer_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_mode_reg <= MODE_FREE;
        end else if (cfg_we) begin
            timer_mode_reg <= cfg_wdata;
        end
    end

    // The front classifies each incoming transaction into a command. A start with a
    // prescaler select of zero or beyond the table is reduced to a stop there.
    logic    push;
    q_item_t push_item;
    logic    q_full;
    logic    q_valid;
    q_item_t q_item;
    logic    q_pop;

    oeit_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // A two-entry queue decouples acceptance from execution, so ticks keep being
    // taken while the output register waits for the consumer, until the queue is full.
    oeit_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (q_pop),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // The back owns the timer state and the output register. Countdown starts use
    // the serial divider to turn milliseconds into a count of prescaled ticks.
    div_req_t div_req;
    div_rsp_t div_rsp;

    oeit_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    oeit_back #(
        .COUNTER_BITS (COUNTER_BITS),
        .CLOCK_HZ     (CLOCK_HZ)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .timer_mode (timer_mode_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // The back must never take a command from an empty queue.
    `OEIT_ASSERT_SAME(a_pop_has_item, q_pop, q_valid, "queue popped while empty")
    // A division is never restarted while one is still running.
    `OEIT_ASSERT_SAME(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted")
    // A started division is busy in the following cycle.
    `OEIT_ASSERT_NEXT(a_div_runs, div_req.start, div_rsp.busy, "divider did not start")
    // No further command is executed while a start is being divided.
    `OEIT_ASSERT_SAME(a_no_pop_in_div, div_rsp.busy, !q_pop, "command taken during division")

endmodule

// ----- sv/oeit_front.sv -----
`timescale 1ns / 1ps

module oeit_front import oeit_pkg::*; (
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     q_full,
    output logic     push,
    output q_item_t  push_item
);

    // A start with an unusable prescaler select only stops the timer, so it
    // is turned into a stop here and the back never sees it as a start.
    always_comb begin
        push_item.sel = s_data.prescale_sel;
        push_item.ms  = s_data.desired_ms;
        case (s_data.req_type)
            REQ_TICK: begin
                push_item.cmd = CMD_TICK;
            end
            REQ_START: begin
                if (s_data.prescale_sel == PSC_OFF || s_data.prescale_sel > PSC_SEL_1024) begin
                    push_item.cmd = CMD_STOP;
                end else begin
                    push_item.cmd = CMD_START;
                end
            end
            REQ_STOP: begin
                push_item.cmd = CMD_STOP;
            end
            default: begin
                push_item.cmd = CMD_NOP;
            end
        endcase
    end

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

endmodule

// ----- sv/oeit_fifo.sv -----
`timescale 1ns / 1ps

module oeit_fifo import oeit_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  q_item_t push_item,
    input  logic    pop,
    output logic    full,
    output logic    q_valid,
    output q_item_t q_item
);

    q_item_t              entries_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;

    assign full    = count_reg == Q_CNT_W'(Q_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_item  = entries_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- sv/oeit_div.sv -----
`timescale 1ns / 1ps

module oeit_div import oeit_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t div_req,
    output div_rsp_t div_rsp
);

    // Restoring division, one quotient bit per cycle. The quotient bits shift
    // in at the bottom of quo_reg as the dividend bits shift out at the top.
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVD_W-1:0]     quo_reg, quo_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DVS_W:0]       trial;
    logic [DVS_W:0]       diff;
    logic                 fits;

    always_comb begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        fits      = trial >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (div_req.start) begin
            rem_next  = '0;
            quo_next  = div_req.dividend;
            dvs_next  = div_req.divisor;
            cnt_next  = DIV_CNT_W'(DVD_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign div_rsp.busy     = busy_reg;
    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = quo_reg;

endmodule

// ----- sv/oeit_back.sv -----
`timescale 1ns / 1ps

module oeit_back import oeit_pkg::*; #(
    parameter int COUNTER_BITS = 8,
    parameter int CLOCK_HZ     = 16000000
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] timer_mode,
    input  logic       q_valid,
    input  q_item_t    q_item,
    output logic       q_pop,
    output div_req_t   div_req,
    input  div_rsp_t   div_rsp,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    localparam int N = COUNTER_BITS;

    // Tick period in ns for each prescaler, floored, never below 1 ns.
    localparam longint unsigned NS_PER_S  = 64'd1000000000;
    localparam longint unsigned TNS_1_R   = (NS_PER_S * 64'd1) / CLOCK_HZ;
    localparam longint unsigned TNS_8_R   = (NS_PER_S * 64'd8) / CLOCK_HZ;
    localparam longint unsigned TNS_64_R  = (NS_PER_S * 64'd64) / CLOCK_HZ;
    localparam longint unsigned TNS_256_R = (NS_PER_S * 64'd256) / CLOCK_HZ;
    localparam longint unsigned TNS_1K_R  = (NS_PER_S * 64'd1024) / CLOCK_HZ;
    localparam logic [DVS_W-1:0] TNS_1    = DVS_W'((TNS_1_R == 64'd0) ? 64'd1 : TNS_1_R);
    localparam logic [DVS_W-1:0] TNS_8    = DVS_W'((TNS_8_R == 64'd0) ? 64'd1 : TNS_8_R);
    localparam logic [DVS_W-1:0] TNS_64   = DVS_W'((TNS_64_R == 64'd0) ? 64'd1 : TNS_64_R);
    localparam logic [DVS_W-1:0] TNS_256  = DVS_W'((TNS_256_R == 64'd0) ? 64'd1 : TNS_256_R);
    localparam logic [DVS_W-1:0] TNS_1K   = DVS_W'((TNS_1K_R == 64'd0) ? 64'd1 : TNS_1K_R);

    bk_state_t         state_reg, state_next;
    logic [N-1:0]      tick_cnt_reg, tick_cnt_next;
    logic [15:0]       ovf_cnt_reg, ovf_cnt_next;
    logic [15:0]       rld_ovf_reg, rld_ovf_next;
    logic [N-1:0]      rld_val_reg, rld_val_next;
    logic [2:0]        act_psc_reg, act_psc_next;
    logic [DIVC_W-1:0] div_cnt_reg, div_cnt_next;
    logic [2:0]        cmd_sel_reg, cmd_sel_next;
    logic [15:0]       cmd_ms_reg, cmd_ms_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    logic              out_free;
    logic              load_out;
    logic              complete;
    logic [DIVC_W-1:0] dc_inc;
    logic [N-1:0]      tc_inc;
    logic [15:0]       ovf_inc;
    logic [15:0]       ovf_dec;
    logic [N-1:0]      rv_calc;
    logic [DVD_W-1:0]  q_hi;
    logic [DVD_W:0]    ovf_sum;
    logic [15:0]       ovf_sat;
    logic [39:0]       tick_wide;
    logic [DVS_W-1:0]  tns_sel;

    always_comb begin
        case (cmd_sel_reg)
            PSC_SEL_1:    tns_sel = TNS_1;
            PSC_SEL_8:    tns_sel = TNS_8;
            PSC_SEL_64:   tns_sel = TNS_64;
            PSC_SEL_256:  tns_sel = TNS_256;
            default:      tns_sel = TNS_1K;
        endcase
    end

    // The multiplier feeds the divider's operand registers directly.
    assign div_req.dividend = {20'd0, cmd_ms_reg} * {16'd0, MS_TO_NS};
    assign div_req.divisor  = tns_sel;

    always_comb begin
        state_next    = state_reg;
        tick_cnt_next = tick_cnt_reg;
        ovf_cnt_next  = ovf_cnt_reg;
        rld_ovf_next  = rld_ovf_reg;
        rld_val_next  = rld_val_reg;
        act_psc_next  = act_psc_reg;
        div_cnt_next  = div_cnt_reg;
        cmd_sel_next  = cmd_sel_reg;
        cmd_ms_next   = cmd_ms_reg;
        q_pop         = 1'b0;
        load_out      = 1'b0;
        complete      = 1'b0;
        div_req.start = 1'b0;

        out_free = !m_valid_reg || m_ready;
        dc_inc   = div_cnt_reg + 1'b1;
        tc_inc   = tick_cnt_reg + 1'b1;
        ovf_inc  = ovf_cnt_reg + 16'd1;
        ovf_dec  = ovf_cnt_reg - 16'd1;

        // Reload value and overflow count from the interval in ticks.
        rv_calc = {N{1'b0}} - div_rsp.quotient[N-1:0];
        q_hi    = div_rsp.quotient >> N;
        ovf_sum = {1'b0, q_hi} + (DVD_W + 1)'(rv_calc != '0);
        ovf_sat = (ovf_sum > (DVD_W + 1)'(OVF_MAX)) ? OVF_MAX : ovf_sum[15:0];

        case (state_reg)
            BK_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    case (q_item.cmd)
                        CMD_TICK: begin
                            load_out = 1'b1;
                            if (act_psc_reg != PSC_OFF) begin
                                if (dc_inc >= psc_divisor(act_psc_reg)) begin
                                    div_cnt_next  = '0;
                                    tick_cnt_next = tc_inc;
                                    if (tc_inc == '0) begin
                                        if (timer_mode == MODE_FREE) begin
                                            ovf_cnt_next = ovf_inc;
                                        end else begin
                                            ovf_cnt_next = ovf_dec;
                                            if (ovf_dec == '0) begin
                                                complete = 1'b1;
                                                if (timer_mode == MODE_ONCE) begin
                                                    act_psc_next = PSC_OFF;
                                                end else begin
                                                    ovf_cnt_next  = rld_ovf_reg;
                                                    tick_cnt_next = rld_val_reg;
                                                end
                                            end
                                        end
                                    end
                                end else begin
                                    div_cnt_next = dc_inc;
                                end
                            end
                        end
                        CMD_START: begin
                            if (timer_mode == MODE_FREE) begin
                                load_out      = 1'b1;
                                rld_ovf_next  = '0;
                                rld_val_next  = '0;
                                ovf_cnt_next  = '0;
                                tick_cnt_next = '0;
                                div_cnt_next  = '0;
                                act_psc_next  = q_item.sel;
                            end else begin
                                act_psc_next = PSC_OFF;
                                cmd_sel_next = q_item.sel;
                                cmd_ms_next  = q_item.ms;
                                state_next   = BK_MUL;
                            end
                        end
                        CMD_STOP: begin
                            load_out     = 1'b1;
                            act_psc_next = PSC_OFF;
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            BK_MUL: begin
                div_req.start = 1'b1;
                state_next    = BK_DIV;
            end
            BK_DIV: begin
                if (div_rsp.done) begin
                    state_next = BK_FIN;
                end
            end
            BK_FIN: begin
                if (out_free) begin
                    load_out      = 1'b1;
                    rld_val_next  = rv_calc;
                    rld_ovf_next  = ovf_sat;
                    ovf_cnt_next  = ovf_sat;
                    tick_cnt_next = rv_calc;
                    div_cnt_next  = '0;
                    act_psc_next  = cmd_sel_reg;
                    state_next    = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        tick_wide              = 40'({ovf_cnt_next, tick_cnt_next});
        m_data_next            = m_data_reg;
        m_valid_next           = m_valid_reg;
        if (load_out) begin
            m_data_next.tick_count = tick_wide[23:0];
            m_data_next.running    = act_psc_next != PSC_OFF;
            m_data_next.complete   = complete;
            m_valid_next           = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            tick_cnt_reg <= '0;
            ovf_cnt_reg  <= '0;
            rld_ovf_reg  <= '0;
            rld_val_reg  <= '0;
            act_psc_reg  <= PSC_OFF;
            div_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tick_cnt_reg <= tick_cnt_next;
            ovf_cnt_reg  <= ovf_cnt_next;
            rld_ovf_reg  <= rld_ovf_next;
            rld_val_reg  <= rld_val_next;
            act_psc_reg  <= act_psc_next;
            div_cnt_reg  <= div_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_sel_reg <= cmd_sel_next;
        cmd_ms_reg  <= cmd_ms_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
